// ===== hw/rtl/hsv_to_rgb_converter_defines.svh =====
// -----------------------------------------------------------------------------
// hsv_to_rgb_converter_defines.svh
// assertion macros shared by the converter's checker
// -----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// consequent checked on the same edge as the antecedent
`define HSVRGB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsv_to_rgb_converter: check failed");

// consequent checked on the edge after the antecedent completes
`define HSVRGB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsv_to_rgb_converter: check failed");

`endif

// ===== hw/rtl/hsvrgb_pkg.sv =====
// -----------------------------------------------------------------------------
// hsvrgb_pkg
// item types, stage types and constants of the hsv to rgb converter
// -----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam logic [8:0]  FULL_CIRCLE   = 9'd360;
	localparam logic [7:0]  CHAN_MAX      = 8'd255;
	localparam logic [5:0]  SECTOR_SPAN   = 6'd60;
	// floor(x/60) == (x * RECIP60) >> RECIP60_SHIFT for x up to 255*60
	localparam logic [14:0] RECIP60       = 15'd17477;
	localparam int          RECIP60_SHIFT = 20;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	typedef struct packed {
		logic [8:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
		logic [7:0] alpha_in;
	} hsv_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha_out;
	} rgb_item_t;

	// stage 1: sector decoded
	typedef struct packed {
		sector_t    sector;
		logic [5:0] rem;
		logic [7:0] sat;
		logic [7:0] val;
		logic [7:0] alpha;
		logic       gray;
		logic       black;
	} stage1_t;

	// stage 2: saturation products
	typedef struct packed {
		sector_t     sector;
		logic [7:0]  val;
		logic [7:0]  alpha;
		logic        gray;
		logic        black;
		logic [13:0] prod_up;
		logic [13:0] prod_dn;
		logic [15:0] prod_c1;
	} stage2_t;

	// stage 3: scaled saturation terms
	typedef struct packed {
		sector_t    sector;
		logic [7:0] val;
		logic [7:0] alpha;
		logic       gray;
		logic       black;
		logic [7:0] sub_up;
		logic [7:0] sub_dn;
		logic [7:0] c1;
	} stage3_t;

	// stage 4: brightness products
	typedef struct packed {
		sector_t     sector;
		logic [7:0]  val;
		logic [7:0]  alpha;
		logic        gray;
		logic        black;
		logic [7:0]  c1;
		logic [15:0] prod_up;
		logic [15:0] prod_dn;
	} stage4_t;

endpackage

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// -----------------------------------------------------------------------------
// hsv_to_rgb_converter
// five stage pipelined integer hsv to 8-bit rgb pixel converter
// -----------------------------------------------------------------------------
// usage
//   input channel hsv (hsv_valid / hsv_ready) carries one pixel item: hue in
//   degrees, saturation, brightness and alpha. output channel rgb
//   (rgb_valid / rgb_ready) carries one result item per input item, in order.
//   zero saturation gives gray; a hue of 360 or more with nonzero saturation
//   gives black. alpha always passes through.
// timing
//   rgb_valid is registered: it is the valid bit of the last stage register.
//   throughput is one item per cycle while the receiver takes results: the
//   five stages are register separated (sector decode, saturation multiply,
//   divide by 60 and 255, brightness multiply, divide by 255 and channel
//   select).
// stalls
//   each stage holds its item while the stage after it is full and blocked,
//   so a stalled receiver fills bubbles first and only then drops hsv_ready.
//   hsv_ready depends combinationally on rgb_ready through that chain.
// reset
//   arst_n clears all stage valid bits; the payload registers are not reset.
// -----------------------------------------------------------------------------
module hsv_to_rgb_converter
	import hsvrgb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      hsv_valid,
	output logic      hsv_ready,
	input  hsv_item_t hsv,
	output logic      rgb_valid,
	input  logic      rgb_ready,
	output rgb_item_t rgb
);

	// stage valid bits and stage advance enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	stage1_t   pipe_s1, next_s1;
	stage2_t   pipe_s2, next_s2;
	stage3_t   pipe_s3, next_s3;
	stage4_t   pipe_s4, next_s4;
	rgb_item_t rgb_s5, next_s5;

	// a stage may load when it is empty or its item moves on this edge
	assign en_s5     = !valid_s5 || rgb_ready;
	assign en_s4     = !valid_s4 || en_s5;
	assign en_s3     = !valid_s3 || en_s4;
	assign en_s2     = !valid_s2 || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign hsv_ready = en_s1;
	assign rgb_valid = valid_s5;
	assign rgb       = rgb_s5;

	// stage 1: sector and offset inside the sector
	sector_t    dec_sector;
	logic [5:0] dec_rem;
	logic       dec_black;

	hsvrgb_sector u_sector (
		.hue    (hsv.hue),
		.sector (dec_sector),
		.rem    (dec_rem),
		.black  (dec_black)
	);

	always_comb begin
		next_s1.sector = dec_sector;
		next_s1.rem    = dec_rem;
		next_s1.sat    = hsv.saturation;
		next_s1.val    = hsv.brightness;
		next_s1.alpha  = hsv.alpha_in;
		next_s1.gray   = (hsv.saturation == 8'd0);
		next_s1.black  = dec_black;
	end

	// stage 2: s*r, s*(60-r) and v*(255-s)
	// t = 6*r, so s*t/360 is s*r/60 and s*(360-t)/360 is s*(60-r)/60
	always_comb begin
		next_s2.sector  = pipe_s1.sector;
		next_s2.val     = pipe_s1.val;
		next_s2.alpha   = pipe_s1.alpha;
		next_s2.gray    = pipe_s1.gray;
		next_s2.black   = pipe_s1.black;
		next_s2.prod_up = 14'(pipe_s1.sat) * 14'(pipe_s1.rem);
		next_s2.prod_dn = 14'(pipe_s1.sat) * 14'(SECTOR_SPAN - pipe_s1.rem);
		next_s2.prod_c1 = 16'(pipe_s1.val) * 16'(CHAN_MAX - pipe_s1.sat);
	end

	// stage 3: divide the saturation products by 60, c1 by 255
	logic [7:0] quo_up, quo_dn, quo_c1;

	hsvrgb_div60 u_div60_up (
		.num (pipe_s2.prod_up),
		.quo (quo_up)
	);

	hsvrgb_div60 u_div60_dn (
		.num (pipe_s2.prod_dn),
		.quo (quo_dn)
	);

	hsvrgb_div255 u_div255_c1 (
		.num (pipe_s2.prod_c1),
		.quo (quo_c1)
	);

	always_comb begin
		next_s3.sector = pipe_s2.sector;
		next_s3.val    = pipe_s2.val;
		next_s3.alpha  = pipe_s2.alpha;
		next_s3.gray   = pipe_s2.gray;
		next_s3.black  = pipe_s2.black;
		next_s3.sub_up = quo_up;
		next_s3.sub_dn = quo_dn;
		next_s3.c1     = quo_c1;
	end

	// stage 4: v*(255-sub) for the rising and falling terms
	always_comb begin
		next_s4.sector  = pipe_s3.sector;
		next_s4.val     = pipe_s3.val;
		next_s4.alpha   = pipe_s3.alpha;
		next_s4.gray    = pipe_s3.gray;
		next_s4.black   = pipe_s3.black;
		next_s4.c1      = pipe_s3.c1;
		next_s4.prod_up = 16'(pipe_s3.val) * 16'(CHAN_MAX - pipe_s3.sub_up);
		next_s4.prod_dn = 16'(pipe_s3.val) * 16'(CHAN_MAX - pipe_s3.sub_dn);
	end

	// stage 5: final divide by 255 and channel order per sector
	logic [7:0] c2, c3;

	hsvrgb_div255 u_div255_c2 (
		.num (pipe_s4.prod_up),
		.quo (c2)
	);

	hsvrgb_div255 u_div255_c3 (
		.num (pipe_s4.prod_dn),
		.quo (c3)
	);

	always_comb begin
		next_s5.alpha_out = pipe_s4.alpha;
		if (pipe_s4.gray) begin
			// gray wins over an out of range hue
			next_s5.red   = pipe_s4.val;
			next_s5.green = pipe_s4.val;
			next_s5.blue  = pipe_s4.val;
		end else if (pipe_s4.black) begin
			next_s5.red   = 8'd0;
			next_s5.green = 8'd0;
			next_s5.blue  = 8'd0;
		end else begin
			unique case (pipe_s4.sector)
				SEC_RED: begin
					next_s5.red   = pipe_s4.val;
					next_s5.green = c3;
					next_s5.blue  = pipe_s4.c1;
				end
				SEC_YELLOW: begin
					next_s5.red   = c2;
					next_s5.green = pipe_s4.val;
					next_s5.blue  = pipe_s4.c1;
				end
				SEC_GREEN: begin
					next_s5.red   = pipe_s4.c1;
					next_s5.green = pipe_s4.val;
					next_s5.blue  = c3;
				end
				SEC_CYAN: begin
					next_s5.red   = pipe_s4.c1;
					next_s5.green = c2;
					next_s5.blue  = pipe_s4.val;
				end
				SEC_BLUE: begin
					next_s5.red   = c3;
					next_s5.green = pipe_s4.c1;
					next_s5.blue  = pipe_s4.val;
				end
				default: begin
					// magenta sector
					next_s5.red   = pipe_s4.val;
					next_s5.green = pipe_s4.c1;
					next_s5.blue  = c2;
				end
			endcase
		end
	end

	// valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= hsv_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// payload registers load only when a real item moves in
	always_ff @(posedge clk) begin
		if (en_s1 && hsv_valid) pipe_s1 <= next_s1;
		if (en_s2 && valid_s1)  pipe_s2 <= next_s2;
		if (en_s3 && valid_s2)  pipe_s3 <= next_s3;
		if (en_s4 && valid_s3)  pipe_s4 <= next_s4;
		if (en_s5 && valid_s4)  rgb_s5  <= next_s5;
	end

endmodule

// ===== hw/rtl/hsvrgb_sector.sv =====
// -----------------------------------------------------------------------------
// hsvrgb_sector
// splits the hue into a 60 degree sector and the offset inside it
// -----------------------------------------------------------------------------
module hsvrgb_sector
	import hsvrgb_pkg::*;
(
	input  logic [8:0] hue,
	output sector_t    sector,
	output logic [5:0] rem,
	output logic       black
);

	localparam logic [8:0] SPAN9 = {3'b000, SECTOR_SPAN};

	logic [8:0] base;

	always_comb begin
		black = (hue >= FULL_CIRCLE);
		priority if (hue < SPAN9) begin
			sector = SEC_RED;
			base   = 9'd0;
		end else if (hue < 9'(2 * SPAN9)) begin
			sector = SEC_YELLOW;
			base   = SPAN9;
		end else if (hue < 9'(3 * SPAN9)) begin
			sector = SEC_GREEN;
			base   = 9'(2 * SPAN9);
		end else if (hue < 9'(4 * SPAN9)) begin
			sector = SEC_CYAN;
			base   = 9'(3 * SPAN9);
		end else if (hue < 9'(5 * SPAN9)) begin
			sector = SEC_BLUE;
			base   = 9'(4 * SPAN9);
		end else if (hue < FULL_CIRCLE) begin
			sector = SEC_MAGENTA;
			base   = 9'(5 * SPAN9);
		end else begin
			// out of range, result is forced black later unless saturation is zero
			sector = SEC_RED;
			base   = hue;
		end
		rem = 6'(hue - base);
	end

endmodule

// ===== hw/rtl/hsvrgb_div60.sv =====
// -----------------------------------------------------------------------------
// hsvrgb_div60
// floor division by 60 through a reciprocal multiply
// -----------------------------------------------------------------------------
module hsvrgb_div60
	import hsvrgb_pkg::*;
(
	input  logic [13:0] num,
	output logic [7:0]  quo
);

	logic [28:0] prod;

	// exact for num up to 255*60, quotient fits eight bits
	assign prod = 29'(num) * 29'(RECIP60);
	assign quo  = prod[RECIP60_SHIFT +: 8];

endmodule

// ===== hw/rtl/hsvrgb_div255.sv =====
// -----------------------------------------------------------------------------
// hsvrgb_div255
// floor division by 255 of a product of two bytes, shift and add only
// -----------------------------------------------------------------------------
module hsvrgb_div255 (
	input  logic [15:0] num,
	output logic [7:0]  quo
);

	logic [16:0] sum;

	// (n + n/256 + 1) / 256 equals n / 255 for n up to 255*255
	assign sum = {1'b0, num} + {9'b0, num[15:8]} + 17'd1;
	assign quo = sum[15:8];

endmodule

// ===== hw/rtl/hsvrgb_checker.sv =====
// -----------------------------------------------------------------------------
// hsvrgb_checker
// port level checks of the hsv to rgb converter, bound to the top level
// -----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsvrgb_checker
	import hsvrgb_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      hsv_valid,
	input logic      hsv_ready,
	input hsv_item_t hsv,
	input logic      rgb_valid,
	input logic      rgb_ready,
	input rgb_item_t rgb
);

	// a stalled result item holds
	`HSVRGB_ASSERT_NEXT(a_rgb_hold, rgb_valid && !rgb_ready, rgb_valid && $stable(rgb))

	// an open receiver never blocks the input
	`HSVRGB_ASSERT_NOW(a_ready_flow, rgb_ready, hsv_ready)

	// with the receiver open, an accepted item appears at the output with its alpha
	`HSVRGB_ASSERT_NEXT(a_alpha_latency, (hsv_valid && hsv_ready) ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready, rgb_valid && (rgb.alpha_out == $past(hsv.alpha_in, 5)))

	// zero saturation gives gray
	`HSVRGB_ASSERT_NEXT(a_gray, (hsv_valid && hsv_ready && (hsv.saturation == 8'd0)) ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready, (rgb.red == $past(hsv.brightness, 5)) && (rgb.green == $past(hsv.brightness, 5)) && (rgb.blue == $past(hsv.brightness, 5)))

	// out of range hue with color gives black
	`HSVRGB_ASSERT_NEXT(a_black, (hsv_valid && hsv_ready && (hsv.saturation != 8'd0) && (hsv.hue >= FULL_CIRCLE)) ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready, (rgb.red == 8'd0) && (rgb.green == 8'd0) && (rgb.blue == 8'd0))

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.hsv_valid (hsv_valid),
	.hsv_ready (hsv_ready),
	.hsv       (hsv),
	.rgb_valid (rgb_valid),
	.rgb_ready (rgb_ready),
	.rgb       (rgb)
);

// ===== sim/tb_hsv_to_rgb_converter.sv =====
// -----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// self-checking testbench of the pipelined hsv to rgb pixel converter
// -----------------------------------------------------------------------------
// a directed set of pixels (sector edges, gray, out-of-range hue, channel
// extremes) is followed by random pixels with random gaps on the input side
// and random stalls on the output side. every accepted pixel is converted by
// an integer model in the scoreboard, and every result item is compared field
// by field, in order, with the oldest expected pixel.
// -----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;
	import hsvrgb_pkg::*;

	localparam int unsigned RANDOM_PIXELS = 1130;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned DRAIN_CYCLES  = 12;
	// long output hold that fills the pipeline and stalls the input
	localparam int unsigned HOLD_AT       = 400;
	localparam int unsigned HOLD_CYCLES   = 120;
	// window of items run back to back with no idling on either side
	localparam int unsigned BURST_FROM    = 700;
	localparam int unsigned BURST_TO      = 850;
	localparam int unsigned REPORT_MAX    = 10;

	// -------------------------------------------------------------------------
	// scoreboard: integer pixel conversion and in-order result check
	// -------------------------------------------------------------------------
	class pixel_scoreboard;
		rgb_item_t   pending_rgb[$];
		int unsigned checked_count;
		int unsigned failure_count;
		int unsigned gray_count;
		int unsigned black_count;
		int unsigned sector_hits[6];

		function rgb_item_t convert_pixel(hsv_item_t px);
			int unsigned h, s, v, circle, span, full, t, c1, c2, c3;
			rgb_item_t   res;
			h      = px.hue;
			s      = px.saturation;
			v      = px.brightness;
			circle = FULL_CIRCLE;
			span   = SECTOR_SPAN;
			full   = CHAN_MAX;
			res    = '0;
			res.alpha_out = px.alpha_in;
			if (s == 0) begin
				// gray wins over an out-of-range hue
				res.red   = 8'(v);
				res.green = 8'(v);
				res.blue  = 8'(v);
			end else if (h < circle) begin
				t  = (h * (circle / span)) % circle;
				c1 = v * (full - s) / full;
				c2 = v * (full - s * t / circle) / full;
				c3 = v * (full - s * (circle - t) / circle) / full;
				case (sector_t'(h / span))
					SEC_RED: begin
						res.red = 8'(v); res.green = 8'(c3); res.blue = 8'(c1);
					end
					SEC_YELLOW: begin
						res.red = 8'(c2); res.green = 8'(v); res.blue = 8'(c1);
					end
					SEC_GREEN: begin
						res.red = 8'(c1); res.green = 8'(v); res.blue = 8'(c3);
					end
					SEC_CYAN: begin
						res.red = 8'(c1); res.green = 8'(c2); res.blue = 8'(v);
					end
					SEC_BLUE: begin
						res.red = 8'(c3); res.green = 8'(c1); res.blue = 8'(v);
					end
					default: begin
						res.red = 8'(v); res.green = 8'(c1); res.blue = 8'(c2);
					end
				endcase
			end
			// hue of 360 and up with color: black, alpha kept
			return res;
		endfunction

		function void note_pixel(hsv_item_t px);
			if (px.saturation == 0)
				gray_count++;
			else if (px.hue >= FULL_CIRCLE)
				black_count++;
			else
				sector_hits[px.hue / SECTOR_SPAN]++;
			pending_rgb.push_back(convert_pixel(px));
		endfunction

		function void check_pixel(rgb_item_t got);
			rgb_item_t want;
			if (pending_rgb.size() == 0) begin
				failure_count++;
				if (failure_count <= REPORT_MAX)
					$display("unexpected result item r=%0d g=%0d b=%0d a=%0d",
						got.red, got.green, got.blue, got.alpha_out);
				return;
			end
			want = pending_rgb.pop_front();
			checked_count++;
			if (got.red !== want.red || got.green !== want.green ||
					got.blue !== want.blue || got.alpha_out !== want.alpha_out) begin
				failure_count++;
				if (failure_count <= REPORT_MAX)
					$display("pixel %0d mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						checked_count, want.red, want.green, want.blue, want.alpha_out,
						got.red, got.green, got.blue, got.alpha_out);
			end
		endfunction
	endclass

	// -------------------------------------------------------------------------
	// clock, reset and the block
	// -------------------------------------------------------------------------
	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      hsv_valid = 1'b0;
	logic      hsv_ready;
	hsv_item_t hsv = '0;
	logic      rgb_valid;
	logic      rgb_ready = 1'b0;
	rgb_item_t rgb;

	pixel_scoreboard sb;
	int unsigned     sent_count = 0;
	int unsigned     cycle_count = 0;
	int unsigned     held_cycles = 0;
	bit              hold_done = 1'b0;

	always #2 clk = ~clk;

	hsv_to_rgb_converter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb)
	);

	// -------------------------------------------------------------------------
	// monitor: both handshakes sampled at the rising edge
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (hsv_valid && hsv_ready)
				sb.note_pixel(hsv);
			if (rgb_valid && rgb_ready)
				sb.check_pixel(rgb);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, sb.pending_rgb.size());
			$display("[hsv_to_rgb_converter] ERROR");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// sender
	// -------------------------------------------------------------------------
	function automatic bit in_burst();
		return sent_count >= BURST_FROM && sent_count < BURST_TO;
	endfunction

	// mostly back to back or short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (in_burst() || roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// called on a falling edge, returns on a falling edge after acceptance
	task automatic send_pixel(hsv_item_t px);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			hsv_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		hsv_valid <= 1'b1;
		hsv       <= px;
		do
			@(posedge clk);
		while (!hsv_ready);
		sent_count++;
		@(negedge clk);
	endtask

	// random pixel, weighted toward sector edges, out-of-range hues, gray and full saturation
	function automatic hsv_item_t random_pixel();
		hsv_item_t   px;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 68)
			px.hue = 9'($urandom_range(0, 359));
		else if (roll < 84)
			px.hue = 9'(60 * $urandom_range(0, 5) + ($urandom_range(0, 1) ? 59 : 0));
		else
			px.hue = 9'($urandom_range(360, 511));
		roll = $urandom_range(0, 99);
		if (roll < 10)
			px.saturation = 8'd0;
		else if (roll < 20)
			px.saturation = 8'd255;
		else if (roll < 25)
			px.saturation = 8'd1;
		else
			px.saturation = 8'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (roll < 5)
			px.brightness = 8'd0;
		else if (roll < 10)
			px.brightness = 8'd255;
		else
			px.brightness = 8'($urandom_range(0, 255));
		px.alpha_in = 8'($urandom_range(0, 255));
		return px;
	endfunction

	// -------------------------------------------------------------------------
	// receiver: random stalls plus one long hold with the input still offered
	// -------------------------------------------------------------------------
	initial begin
		int unsigned stall_left;
		int unsigned roll;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rgb_ready <= 1'b0;
			end else if (!hold_done && sent_count >= HOLD_AT) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				rgb_ready  <= 1'b0;
			end else begin
				roll = $urandom_range(0, 99);
				if (in_burst() || roll < 60) begin
					rgb_ready <= 1'b1;
				end else if (roll < 94) begin
					stall_left = $urandom_range(0, 3);
					rgb_ready  <= 1'b0;
				end else begin
					stall_left = $urandom_range(10, 40);
					rgb_ready  <= 1'b0;
				end
			end
		end
	end

	// count cycles in which the input was blocked while an item was offered
	always @(posedge clk)
		if (arst_n && hsv_valid && !hsv_ready)
			held_cycles <= held_cycles + 1;

	// -------------------------------------------------------------------------
	// main sequence
	// -------------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every sector, its edges, gray, black and channel extremes
		send_pixel('{9'd0,   8'd255, 8'd255, 8'd0});
		send_pixel('{9'd0,   8'd0,   8'd255, 8'd255});
		send_pixel('{9'd59,  8'd255, 8'd255, 8'd1});
		send_pixel('{9'd60,  8'd255, 8'd255, 8'd2});
		send_pixel('{9'd119, 8'd128, 8'd200, 8'd128});
		send_pixel('{9'd120, 8'd255, 8'd255, 8'd3});
		send_pixel('{9'd180, 8'd255, 8'd128, 8'd4});
		send_pixel('{9'd240, 8'd1,   8'd255, 8'd5});
		send_pixel('{9'd300, 8'd255, 8'd255, 8'd6});
		send_pixel('{9'd359, 8'd255, 8'd255, 8'd254});
		send_pixel('{9'd360, 8'd255, 8'd255, 8'd170});
		send_pixel('{9'd511, 8'd255, 8'd255, 8'd85});
		send_pixel('{9'd511, 8'd0,   8'd200, 8'd255});
		send_pixel('{9'd360, 8'd0,   8'd0,   8'd0});
		send_pixel('{9'd30,  8'd255, 8'd0,   8'd7});
		send_pixel('{9'd210, 8'd1,   8'd1,   8'd8});
		send_pixel('{9'd90,  8'd128, 8'd255, 8'd9});
		send_pixel('{9'd270, 8'd200, 8'd100, 8'd10});
		send_pixel('{9'd330, 8'd255, 8'd255, 8'd255});
		send_pixel('{9'd150, 8'd0,   8'd1,   8'd11});
		send_pixel('{9'd256, 8'd254, 8'd254, 8'd127});

		repeat (RANDOM_PIXELS)
			send_pixel(random_pixel());
		hsv_valid <= 1'b0;

		// drain, then give the pipeline its latency to show any stray item
		while (sb.pending_rgb.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_rgb.size() != 0)
			sb.failure_count += sb.pending_rgb.size();

		$display("%0d pixels converted and checked: %0d gray, %0d black, sectors %0d %0d %0d %0d %0d %0d",
			sb.checked_count, sb.gray_count, sb.black_count, sb.sector_hits[0],
			sb.sector_hits[1], sb.sector_hits[2], sb.sector_hits[3], sb.sector_hits[4],
			sb.sector_hits[5]);
		$display("input blocked for %0d cycles under output stalls, %0d failures",
			held_cycles, sb.failure_count);
		if (sb.failure_count == 0)
			$display("[hsv_to_rgb_converter] OK");
		else
			$display("[hsv_to_rgb_converter] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_sector.sv
hw/rtl/hsvrgb_div60.sv
hw/rtl/hsvrgb_div255.sv
hw/rtl/hsv_to_rgb_converter.sv
hw/rtl/hsvrgb_checker.sv
sim/tb_hsv_to_rgb_converter.sv
